[src/pfkm_pkg.sv]
// Package: constants, token and result types for the keyword match chain.
package pfkm_pkg;

    localparam int MaxKeywords   = 16;
    localparam int MaxKeywordLen = 32;
    localparam int RegionBytes   = 1048576;
    localparam int NeededHits    = 3;

    localparam logic [7:0] LowPrint  = 8'd32;
    localparam logic [7:0] HighPrint = 8'd125;
    localparam logic [7:0] NewLine   = 8'd10;

    localparam logic KindLoad = 1'b0;
    localparam logic KindScan = 1'b1;

    typedef logic [MaxKeywordLen-1:0][7:0] t_window;

    // running selection of the lowest matched indices
    typedef struct packed {
        logic [1:0]  hits;
        logic [3:0]  idx0;
        logic [3:0]  idx1;
        logic [3:0]  idx2;
        logic [19:0] off;
    } t_acc;

    // item travelling down the cell chain
    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [3:0]  slot;
        logic [4:0]  pos;
        logic [5:0]  len;
        logic [7:0]  data;
        logic        last;
        logic        keep;
        logic [20:0] kcnt;
        t_window     win;
        t_acc        acc;
    } t_tok;

    typedef struct packed {
        logic        region_hit;
        logic [3:0]  first_index;
        logic [3:0]  second_index;
        logic [3:0]  third_index;
        logic [19:0] third_match_offset;
        logic [20:0] filtered_length;
    } t_res;

endpackage

[src/pfkm_if.sv]
// Interfaces: input item channel and result channel.
interface pfkm_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [3:0] keyword_slot;
    logic [4:0] char_position;
    logic [5:0] keyword_length;
    logic [7:0] data_byte;
    logic       last_of_region;
    modport source (output valid, kind, keyword_slot, char_position, keyword_length,
                    data_byte, last_of_region, input ready);
    modport sink (input valid, kind, keyword_slot, char_position, keyword_length,
                  data_byte, last_of_region, output ready);
endinterface

interface pfkm_out_if;
    logic        valid;
    logic        ready;
    logic        region_hit;
    logic [3:0]  first_index;
    logic [3:0]  second_index;
    logic [3:0]  third_index;
    logic [19:0] third_match_offset;
    logic [20:0] filtered_length;
    modport source (output valid, region_hit, first_index, second_index, third_index,
                    third_match_offset, filtered_length, input ready);
    modport sink (input valid, region_hit, first_index, second_index, third_index,
                  third_match_offset, filtered_length, output ready);
endinterface

[src/pfkm_front.sv]
// Front stage: printable filter, kept count and history window.
module pfkm_front
    import pfkm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  logic       i_kind,
    input  logic [3:0] i_slot,
    input  logic [4:0] i_pos,
    input  logic [5:0] i_len,
    input  logic [7:0] i_data,
    input  logic       i_last,
    output t_tok       o_tok
);
    logic [20:0] r_cnt, n_cnt;
    t_window     r_win, n_win;
    t_tok        r_tok, n_tok;
    logic        keep;
    logic        acc_ok;

    // filter and window shift
    always_comb begin
        acc_ok = i_en && i_valid;
        keep   = (i_kind == KindScan)
                 && (((i_data >= LowPrint) && (i_data <= HighPrint)) || (i_data == NewLine))
                 && (r_cnt < 21'(RegionBytes));
        n_cnt = keep ? r_cnt + 21'd1 : r_cnt;
        n_win = keep ? {r_win[MaxKeywordLen-2:0], i_data} : r_win;
        n_tok.valid = acc_ok;
        n_tok.kind  = i_kind;
        n_tok.slot  = i_slot;
        n_tok.pos   = i_pos;
        n_tok.len   = (i_len > 6'(MaxKeywordLen)) ? 6'(MaxKeywordLen) : i_len;
        n_tok.data  = i_data;
        n_tok.last  = i_last && (i_kind == KindScan);
        n_tok.keep  = keep;
        n_tok.kcnt  = n_cnt;
        n_tok.win   = n_win;
        n_tok.acc   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_win       <= '0;
            r_tok.valid <= 1'b0;
        end else if (i_en) begin
            r_tok <= n_tok;
            if (acc_ok && (i_kind == KindScan)) begin
                if (i_last) begin
                    r_cnt <= '0;
                    r_win <= '0;
                end else begin
                    r_cnt <= n_cnt;
                    r_win <= n_win;
                end
            end
        end
    end

    assign o_tok = r_tok;
endmodule

[src/pfkm_cell.sv]
// Keyword cell: one keyword, its match state and one step of the result selection.
module pfkm_cell
    import pfkm_pkg::*;
#(
    parameter int K = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [4:0] i_count,
    input  t_tok       i_tok,
    output t_tok       o_tok
);
    logic [MaxKeywordLen-1:0][7:0] r_kw;
    logic [5:0]  r_len;
    logic        r_found;
    logic [19:0] r_off;
    t_tok        r_tok, n_tok;

    logic        active, eq_all, hit_now, found_now, scan_ok;
    logic [19:0] off_new, off_now;
    logic [5:0]  sel;

    // compare keyword against the newest kept bytes
    always_comb begin
        sel    = '0;
        eq_all = 1'b1;
        for (int p = 0; p < MaxKeywordLen; p++) begin
            sel = r_len - 6'd1 - 6'(p);
            if (6'(p) < r_len) begin
                if (i_tok.win[sel[4:0]] != r_kw[p]) eq_all = 1'b0;
            end
        end
        active    = 5'(K) < i_count;
        scan_ok   = i_tok.valid && (i_tok.kind == KindScan);
        hit_now   = scan_ok && i_tok.keep && active && !r_found && (r_len != 6'd0)
                    && ({15'd0, r_len} <= i_tok.kcnt) && eq_all;
        off_new   = 20'(i_tok.kcnt - {15'd0, r_len});
        found_now = r_found || hit_now;
        off_now   = (r_len == 6'd0) ? 20'd0 : (hit_now ? off_new : r_off);
    end

    // selection step for the region result
    always_comb begin
        n_tok = i_tok;
        if (scan_ok && i_tok.last && active && (found_now || (r_len == 6'd0))
            && (i_tok.acc.hits < 2'(NeededHits))) begin
            case (i_tok.acc.hits)
                2'd0:    n_tok.acc.idx0 = 4'(K);
                2'd1:    n_tok.acc.idx1 = 4'(K);
                default: n_tok.acc.idx2 = 4'(K);
            endcase
            n_tok.acc.off  = off_now;
            n_tok.acc.hits = i_tok.acc.hits + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_found     <= 1'b0;
            r_tok.valid <= 1'b0;
        end else if (i_en) begin
            r_tok <= n_tok;
            if (i_tok.valid && (i_tok.kind == KindLoad) && (i_tok.slot == 4'(K))) begin
                r_len            <= i_tok.len;
                r_kw[i_tok.pos]  <= i_tok.data;
            end
            if (hit_now) r_off <= off_new;
            if (scan_ok && i_tok.last) r_found <= 1'b0;
            else if (hit_now)          r_found <= 1'b1;
        end
    end

    assign o_tok = r_tok;
endmodule

[src/pfkm_out_queue.sv]
// Two-entry result queue between the chain and the output channel.
module pfkm_out_queue
    import pfkm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_res,
    output logic o_room,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);
    t_res       r_q [2];
    logic [1:0] r_num;
    logic       r_wp, r_rp;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = r_num != 2'd0;
    assign o_room  = r_num != 2'd2;
    assign o_res   = r_q[r_rp];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (i_push) begin
                r_q[r_wp] <= i_res;
                r_wp      <= ~r_wp;
            end
            if (pop) r_rp <= ~r_rp;
            r_num <= r_num + 2'(i_push) - 2'(pop);
        end
    end
endmodule

[src/printable_filter_multi_keyword_match.sv]
// A region's result item passes the front register, the keyword cell registers and the result queue.
// Throughput: one item per cycle; filter stage, then one pipeline stage per keyword cell.
// The whole chain stalls only while both result queue entries are full.
// Reset (synchronous, active low) clears keyword lengths, found marks, history,
// kept count, keyword_count and all valid flags; keyword characters stay unwritten.
module printable_filter_multi_keyword_match
    import pfkm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    pfkm_in_if.sink    i_item,
    pfkm_out_if.source o_result
);
    logic [4:0] r_count;
    logic       en;
    t_tok       tok [MaxKeywords+1];
    t_tok       tail;
    t_res       res;
    logic       push;
    t_res       q_res;
    logic       q_valid;

    // keyword count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= '0;
        else if (i_cfg_we)
            r_count <= (i_cfg_wdata > 5'(MaxKeywords)) ? 5'(MaxKeywords) : i_cfg_wdata;
    end

    assign i_item.ready = en;

    pfkm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_item.valid),
        .i_kind(i_item.kind), .i_slot(i_item.keyword_slot), .i_pos(i_item.char_position),
        .i_len(i_item.keyword_length), .i_data(i_item.data_byte),
        .i_last(i_item.last_of_region), .o_tok(tok[0])
    );

    // chain of keyword cells
    for (genvar k = 0; k < MaxKeywords; k++) begin : g_cell
        pfkm_cell #(.K(k)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_count(r_count),
            .i_tok(tok[k]), .o_tok(tok[k+1])
        );
    end

    // result formation at the chain tail
    always_comb begin
        tail                   = tok[MaxKeywords];
        push                   = en && tail.valid && (tail.kind == KindScan) && tail.last;
        res.region_hit         = tail.acc.hits == 2'(NeededHits);
        res.first_index        = res.region_hit ? tail.acc.idx0 : 4'd0;
        res.second_index       = res.region_hit ? tail.acc.idx1 : 4'd0;
        res.third_index        = res.region_hit ? tail.acc.idx2 : 4'd0;
        res.third_match_offset = res.region_hit ? tail.acc.off : 20'd0;
        res.filtered_length    = tail.kcnt;
    end

    pfkm_out_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_res(res), .o_room(en),
        .o_valid(q_valid), .i_ready(o_result.ready), .o_res(q_res)
    );

    assign o_result.valid              = q_valid;
    assign o_result.region_hit         = q_res.region_hit;
    assign o_result.first_index        = q_res.first_index;
    assign o_result.second_index       = q_res.second_index;
    assign o_result.third_index        = q_res.third_index;
    assign o_result.third_match_offset = q_res.third_match_offset;
    assign o_result.filtered_length    = q_res.filtered_length;
endmodule
